// ===== sv/gbi_pkg.sv =====
// Shared types and constants for the grid bilinear interpolator.
// Request/response payloads and the divider link carried between cells.
// No dependencies.
package gbi_pkg;

	localparam int VW = 32;        // coordinate and value width
	localparam int NW = 98;        // numerator magnitude width
	localparam int DW = 65;        // denominator magnitude width
	localparam int QW = 42;        // quotient bits kept (41..0)
	localparam int RW = DW + QW;   // compare width in a divider cell

	localparam logic [1:0] MODE_ONE  = 2'd0;
	localparam logic [1:0] MODE_TWO  = 2'd1;
	localparam logic [1:0] MODE_FOUR = 2'd2;
	localparam logic [1:0] MODE_BAD  = 2'd3;

	typedef struct packed {
		logic [1:0]           mode;
		logic signed [VW-1:0] first_x;
		logic signed [VW-1:0] first_y;
		logic signed [VW-1:0] last_x;
		logic signed [VW-1:0] last_y;
		logic signed [VW-1:0] query_x;
		logic signed [VW-1:0] query_y;
		logic signed [VW-1:0] value_0;
		logic signed [VW-1:0] value_1;
		logic signed [VW-1:0] value_2;
		logic signed [VW-1:0] value_3;
	} req_t;

	typedef struct packed {
		logic signed [VW-1:0] interpolated;
		logic                 failed;
	} rsp_t;

	typedef struct packed {
		logic                 vld;
		logic                 neg;
		logic                 fail;
		logic signed [VW-1:0] ofs;
		logic [DW-1:0]        den;
		logic [NW-1:0]        rmd;
		logic [QW-1:0]        quo;
	} link_t;

endpackage

// ===== sv/grid_bilinear_interpolator_core.sv =====
// Grid bilinear interpolator top level: front pipeline, divider cell chain,
// saturation and response register. Depends on gbi_pkg, gbi_front, gbi_div_cell.
//
// Accepts one request per unstalled cycle and returns one response per request,
// in order. It has five front stages (operand select, coordinate products,
// split value products, numerator sum, magnitudes), a chain of 42 division cells
// that each resolve one quotient bit, and the response register. A stalled
// response holds the whole pipeline. Quotients truncate toward zero, clamp at
// 2^40 in magnitude, and the result saturates to 32 bits; failures return 0.
module grid_bilinear_interpolator_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  gbi_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gbi_pkg::rsp_t rsp
);
	import gbi_pkg::*;

	logic  en;
	link_t chain [QW+1];
	link_t tl;

	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	gbi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.req_valid (req_valid),
		.req       (req),
		.head      (chain[0])
	);

	for (genvar k = 0; k < QW; k++) begin : g_cell
		gbi_div_cell #(.SHIFT(QW - 1 - k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.prv    (chain[k]),
			.nxt    (chain[k+1])
		);
	end

	assign tl = chain[QW];

	logic                clamp;
	logic [QW-1:0]       mag;
	logic signed [QW:0]  sq;
	logic signed [QW+1:0] sum;
	logic signed [VW-1:0] res;

	always_comb begin
		clamp = tl.quo[QW-1] | (tl.quo[QW-2] & (|tl.quo[QW-3:0]));
		mag   = clamp ? (QW'(1) << (QW - 2)) : tl.quo;
		sq    = tl.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		sum   = (QW+2)'(tl.ofs) + (QW+2)'(sq);
		if (sum > (QW+2)'(32'sh7fffffff)) begin
			res = 32'sh7fffffff;
		end else if (sum < -(QW+2)'(33'sh080000000)) begin
			res = 32'sh80000000;
		end else begin
			res = sum[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid        <= tl.vld;
			rsp.failed       <= tl.fail;
			rsp.interpolated <= tl.fail ? '0 : res;
		end
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.failed |-> rsp.interpolated == '0)
		else $error("failed response with nonzero value");

	a_tail_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		en && tl.vld |=> rsp_valid)
		else $error("request lost between divider chain and response");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain[QW].quo) && $stable(chain[0].rmd))
		else $error("pipeline moved while response stalled");

endmodule

// ===== sv/gbi_div_cell.sv =====
// One restoring-division cell: resolves a single quotient bit.
// Depends on gbi_pkg (link_t, widths).
module gbi_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  gbi_pkg::link_t prv,
	output gbi_pkg::link_t nxt
);
	import gbi_pkg::*;

	logic [RW-1:0] dsh;
	logic [RW-1:0] rext;
	logic [RW-1:0] rsub;
	logic          ge;

	always_comb begin
		dsh  = RW'(prv.den) << SHIFT;
		rext = RW'(prv.rmd);
		ge   = rext >= dsh;
		rsub = rext - dsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt.vld <= 1'b0;
		end else if (en) begin
			nxt.vld  <= prv.vld;
			nxt.neg  <= prv.neg;
			nxt.fail <= prv.fail;
			nxt.ofs  <= prv.ofs;
			nxt.den  <= prv.den;
			nxt.rmd  <= ge ? rsub[NW-1:0] : prv.rmd;
			nxt.quo  <= {prv.quo[QW-2:0], ge};
		end
	end

endmodule

// ===== sv/gbi_front.sv =====
// Front pipeline: operand select, products, weighted sum, magnitudes.
// Depends on gbi_pkg; feeds the head of the divider cell chain.
module gbi_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           req_valid,
	input  gbi_pkg::req_t  req,
	output gbi_pkg::link_t head
);
	import gbi_pkg::*;

	function automatic logic signed [VW:0] sx(input logic signed [VW-1:0] v);
		return {v[VW-1], v};
	endfunction

	// stage 1
	logic                 vld_s1, fail_s1;
	logic signed [VW:0]   pa_s1 [4];
	logic signed [VW:0]   pb_s1 [4];
	logic signed [VW:0]   da_s1, db_s1;
	logic signed [VW-1:0] coef_s1 [4];
	logic signed [VW-1:0] ofs_s1;

	logic signed [VW:0]   pa_c [4];
	logic signed [VW:0]   pb_c [4];
	logic signed [VW:0]   da_c, db_c;
	logic signed [VW-1:0] coef_c [4];
	logic signed [VW-1:0] ofs_c;
	logic                 fail_c;
	logic signed [VW:0]   dx1, dxq, dy1, dyq, dx, dy;
	logic signed [VW-1:0] ca, cb, cq;

	always_comb begin
		dx1 = sx(req.last_x) - sx(req.query_x);
		dxq = sx(req.query_x) - sx(req.first_x);
		dy1 = sx(req.last_y) - sx(req.query_y);
		dyq = sx(req.query_y) - sx(req.first_y);
		dx  = sx(req.last_x) - sx(req.first_x);
		dy  = sx(req.last_y) - sx(req.first_y);
		if (req.first_x == req.last_x) begin
			ca = req.first_y; cb = req.last_y; cq = req.query_y;
		end else begin
			ca = req.first_x; cb = req.last_x; cq = req.query_x;
		end
		for (int i = 0; i < 4; i++) begin
			pa_c[i]   = '0;
			pb_c[i]   = '0;
			coef_c[i] = '0;
		end
		da_c   = (VW+1)'(1);
		db_c   = (VW+1)'(1);
		ofs_c  = '0;
		fail_c = 1'b0;
		case (req.mode)
			MODE_ONE: begin
				ofs_c = req.value_0;
			end
			MODE_TWO: begin
				pa_c[0]   = sx(req.value_1) - sx(req.value_0);
				pb_c[0]   = sx(cq) - sx(ca);
				coef_c[0] = VW'(1);
				da_c      = sx(cb) - sx(ca);
				ofs_c     = req.value_0;
				fail_c    = (ca == cb);
			end
			MODE_FOUR: begin
				pa_c[0] = dx1; pb_c[0] = dy1; coef_c[0] = req.value_0;
				pa_c[1] = dx1; pb_c[1] = dyq; coef_c[1] = req.value_1;
				pa_c[2] = dxq; pb_c[2] = dy1; coef_c[2] = req.value_2;
				pa_c[3] = dxq; pb_c[3] = dyq; coef_c[3] = req.value_3;
				da_c    = dx;
				db_c    = dy;
				fail_c  = (dx == '0) || (dy == '0);
			end
			default: begin
				fail_c = 1'b1;
			end
		endcase
	end

	// stage 2: coordinate products
	logic                        vld_s2, fail_s2;
	logic signed [2*VW+1:0]      prod_s2 [4];
	logic signed [2*VW+1:0]      den_s2;
	logic signed [VW-1:0]        coef_s2 [4];
	logic signed [VW-1:0]        ofs_s2;

	// stage 3: split value products
	logic                        vld_s3, fail_s3;
	logic signed [2*VW:0]        hi_s3 [4];
	logic signed [2*VW+1:0]      lo_s3 [4];
	logic signed [2*VW+1:0]      den_s3;
	logic signed [VW-1:0]        ofs_s3;

	// stage 4: numerator sum
	logic                        vld_s4, fail_s4;
	logic signed [NW+1:0]        num_s4;
	logic signed [2*VW+1:0]      den_s4;
	logic signed [VW-1:0]        ofs_s4;

	logic signed [NW+1:0]        acc_c;
	logic signed [NW+1:0]        nabs_c;
	logic signed [2*VW+1:0]      dabs_c;

	always_comb begin
		acc_c = '0;
		for (int i = 0; i < 4; i++) begin
			acc_c = acc_c + ((NW+2)'(hi_s3[i]) <<< (VW+1)) + (NW+2)'(lo_s3[i]);
		end
		nabs_c = num_s4[NW+1] ? -num_s4 : num_s4;
		dabs_c = den_s4[2*VW+1] ? -den_s4 : den_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			head.vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= req_valid;
			fail_s1 <= fail_c;
			pa_s1   <= pa_c;
			pb_s1   <= pb_c;
			da_s1   <= da_c;
			db_s1   <= db_c;
			coef_s1 <= coef_c;
			ofs_s1  <= ofs_c;

			vld_s2  <= vld_s1;
			fail_s2 <= fail_s1;
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= pa_s1[i] * pb_s1[i];
			end
			den_s2  <= da_s1 * db_s1;
			coef_s2 <= coef_s1;
			ofs_s2  <= ofs_s1;

			vld_s3  <= vld_s2;
			fail_s3 <= fail_s2;
			for (int i = 0; i < 4; i++) begin
				hi_s3[i] <= $signed(prod_s2[i][2*VW+1:VW+1]) * coef_s2[i];
				lo_s3[i] <= $signed({1'b0, prod_s2[i][VW:0]}) * coef_s2[i];
			end
			den_s3  <= den_s2;
			ofs_s3  <= ofs_s2;

			vld_s4  <= vld_s3;
			fail_s4 <= fail_s3;
			num_s4  <= acc_c;
			den_s4  <= den_s3;
			ofs_s4  <= ofs_s3;

			head.vld  <= vld_s4;
			head.fail <= fail_s4;
			head.neg  <= num_s4[NW+1] ^ den_s4[2*VW+1];
			head.ofs  <= ofs_s4;
			head.den  <= dabs_c[DW-1:0];
			head.rmd  <= nabs_c[NW-1:0];
			head.quo  <= '0;
		end
	end

endmodule

// ===== sim/tb_grid_bilinear_interpolator_core.sv =====
// Testbench for grid_bilinear_interpolator_core: directed and random requests,
// bit-exact prediction of interpolated/failed, in-order scoreboard check.
// Depends on gbi_pkg and the core RTL.
module tb_grid_bilinear_interpolator_core;
	import gbi_pkg::*;

	localparam int N_RANDOM = 1600;
	localparam int LATENCY  = 48;

	class interp_scoreboard;
		rsp_t pending[$];
		int   errors;

		function new();
			errors = 0;
		endfunction

		function rsp_t predict(req_t r);
			rsp_t o;
			logic signed [127:0] num;
			logic signed [127:0] den;
			logic signed [127:0] q;
			logic signed [63:0]  a, b, qq, x0, y0, x1, y1, qx, qy;
			logic signed [63:0]  v0, v1, v2, v3;
			o.interpolated = '0;
			o.failed = 1'b0;
			x0 = r.first_x; y0 = r.first_y; x1 = r.last_x; y1 = r.last_y;
			qx = r.query_x; qy = r.query_y;
			v0 = r.value_0; v1 = r.value_1; v2 = r.value_2; v3 = r.value_3;
			num = 0;
			den = 1;
			case (r.mode)
				MODE_ONE: begin
					o.interpolated = r.value_0;
					return o;
				end
				MODE_TWO: begin
					if (x0 == x1) begin
						a = y0; b = y1; qq = qy;
					end else begin
						a = x0; b = x1; qq = qx;
					end
					if (a == b) begin
						o.failed = 1'b1;
						return o;
					end
					num = 128'(v1 - v0) * 128'(qq - a);
					den = 128'(b - a);
				end
				MODE_FOUR: begin
					if (x1 == x0 || y1 == y0) begin
						o.failed = 1'b1;
						return o;
					end
					num = 128'(v0) * 128'(x1 - qx) * 128'(y1 - qy)
						+ 128'(v1) * 128'(x1 - qx) * 128'(qy - y0)
						+ 128'(v2) * 128'(qx - x0) * 128'(y1 - qy)
						+ 128'(v3) * 128'(qx - x0) * 128'(qy - y0);
					den = 128'(x1 - x0) * 128'(y1 - y0);
				end
				default: begin
					o.failed = 1'b1;
					return o;
				end
			endcase
			q = num / den;
			if (r.mode == MODE_TWO)
				q = q + 128'(v0);
			if (q > 128'sd2147483647)
				o.interpolated = 32'sh7fffffff;
			else if (q < -128'sd2147483648)
				o.interpolated = 32'sh80000000;
			else
				o.interpolated = q[31:0];
			return o;
		endfunction

		function void note_request(req_t r);
			pending = {pending, predict(r)};
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_response(rsp_t got);
			rsp_t exp_rsp;
			if (pending.size() == 0) begin
				report($sformatf("response %h with no request outstanding", got));
				return;
			end
			exp_rsp = pending.pop_front();
			if (got.interpolated !== exp_rsp.interpolated)
				report($sformatf("interpolated %h, expected %h",
					got.interpolated, exp_rsp.interpolated));
			if (got.failed !== exp_rsp.failed)
				report($sformatf("failed %b, expected %b", got.failed, exp_rsp.failed));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic hold_off = 1'b0;
	bit   stim_done = 1'b0;
	event hold_ev;

	interp_scoreboard sb = new();

	grid_bilinear_interpolator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic logic signed [31:0] rand_word(int kind);
		case (kind)
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3, 4: return $signed(32'($urandom_range(0, 20 << 16)) - 32'(10 << 16));
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic req_t rand_request();
		req_t r;
		r.mode    = $urandom_range(0, 15) == 0 ? MODE_BAD : 2'($urandom_range(0, 2));
		r.first_x = rand_word($urandom_range(0, 8));
		r.first_y = rand_word($urandom_range(0, 8));
		r.last_x  = $urandom_range(0, 7) == 0 ? r.first_x : rand_word($urandom_range(0, 8));
		r.last_y  = $urandom_range(0, 7) == 0 ? r.first_y : rand_word($urandom_range(0, 8));
		r.query_x = rand_word($urandom_range(0, 8));
		r.query_y = rand_word($urandom_range(0, 8));
		r.value_0 = rand_word($urandom_range(0, 8));
		r.value_1 = rand_word($urandom_range(0, 8));
		r.value_2 = rand_word($urandom_range(0, 8));
		r.value_3 = rand_word($urandom_range(0, 8));
		return r;
	endfunction

	// called at a rising edge; returns at the accepting edge with valid still high
	task automatic send_request(req_t r, int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic send_and_flow(req_t r);
		send_request(r, $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		req_t r;
		int k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (k = 0; k < 24; k++) begin
			r = '0;
			r.mode = 2'(k % 4);
			r.first_x = 32'sh00010000; r.first_y = 32'sh00010000;
			r.last_x = 32'sh00030000; r.last_y = 32'sh00050000;
			r.query_x = 32'sh00020000; r.query_y = 32'sh00020000;
			r.value_0 = 32'sh00100000; r.value_1 = -32'sh00200000;
			r.value_2 = 32'sh7fffffff; r.value_3 = 32'sh80000000;
			if (k >= 4 && k < 8) r.last_x = r.first_x;
			if (k >= 8 && k < 12) begin
				r.last_x = r.first_x; r.last_y = r.first_y;
			end
			if (k >= 12 && k < 16) r.last_y = r.first_y;
			if (k >= 16 && k < 20) begin
				r.query_x = 32'sh7fffffff; r.query_y = 32'sh80000000;
				r.first_x = 32'sh80000000; r.last_x = 32'sh80000001;
			end
			if (k >= 20) begin
				r.first_x = 32'sh80000000; r.last_x = 32'sh7fffffff;
				r.first_y = 32'sh7fffffff; r.last_y = 32'sh80000000;
				r.value_0 = 32'sh80000000; r.value_1 = 32'sh7fffffff;
				r.value_2 = 32'shffffffff;
			end
			send_request(r, 0);
		end
		for (k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM / 2)
				wait_drained();
			if (k == N_RANDOM / 4)
				-> hold_ev;
			send_and_flow(rand_request());
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		forever begin
			@(hold_ev);
			hold_off <= 1'b1;
			repeat (150) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 13) : 0;
			if (gap != 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (hold_off) begin
				rsp_stall <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/gbi_pkg.sv
sv/gbi_div_cell.sv
sv/gbi_front.sv
sv/grid_bilinear_interpolator_core.sv
sim/tb_grid_bilinear_interpolator_core.sv
